@@ hw/rtl/upsc_pkg.sv @@
// Shared types, constants and helpers for the pixel doubling upscaler.
package upsc_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int IDX_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = 12;
	localparam int PIX_W     = 24;
	localparam int PAIR_W    = 2 * PIX_W;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = QPTR_W + 1;

	localparam logic [WID_W-1:0] MAX_W   = WID_W'(MAX_WIDTH);
	localparam logic [1:0]       PAD_ODD = 2'd2;
	localparam logic [1:0]       PAD_NONE = 2'd0;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_FIRST  = 2'd0,
		ST_SECOND = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	// One classified request as it travels from the front part to the back part.
	typedef struct packed {
		status_t            status;
		logic [PIX_W-1:0]   pixel;
		logic [1:0]         pad;
		logic               row_end;
	} upsc_entry_t;

	// The pixel written twice, first copy in the lowest bits.
	function automatic logic [PAIR_W-1:0] make_pair(input logic [PIX_W-1:0] px);
		make_pair = {px, px};
	endfunction

endpackage

@@ hw/rtl/upsc_front.sv @@
// Front part: takes requests, keeps the row state and the line buffer, classifies each request.
module upsc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [11:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [7:0]                  blue,
	input  logic [7:0]                  green,
	input  logic [7:0]                  red,
	input  logic [upsc_pkg::QCNT_W-1:0] q_level,
	output logic                        q_push,
	output upsc_pkg::upsc_entry_t       q_entry
);
	import upsc_pkg::*;

	logic [WID_W-1:0] source_width_q;
	logic [WID_W-1:0] eff_w;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] rep_idx_q;
	logic             pending_q;
	logic [WID_W-1:0] col_next;
	logic [WID_W-1:0] rep_next;
	logic             col_end;
	logic             rep_end;
	logic [1:0]       row_pad;
	logic             accept;
	logic             do_push;
	logic             do_drain;

	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_q;

	logic             valid_s1;
	status_t          status_s1;
	logic [PIX_W-1:0] px_s1;
	logic [1:0]       pad_s1;
	logic             row_end_s1;

	// Configuration register; the port never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q <= WID_W'(1);
		end else if (cfg_valid) begin
			source_width_q <= cfg_data;
		end
	end

	always_comb begin
		if (source_width_q == '0) begin
			eff_w = WID_W'(1);
		end else if (source_width_q > MAX_W) begin
			eff_w = MAX_W;
		end else begin
			eff_w = source_width_q;
		end
	end

	assign col_next = {1'b0, col_q} + WID_W'(1);
	assign rep_next = {1'b0, rep_idx_q} + WID_W'(1);
	assign col_end  = col_next >= eff_w;
	assign rep_end  = rep_next >= eff_w;
	assign row_pad  = eff_w[0] ? PAD_ODD : PAD_NONE;

	// Room for the item already in the stage plus the one taken now.
	assign in_ready = (q_level + QCNT_W'(valid_s1)) < QCNT_W'(QDEPTH);
	assign accept   = in_valid && in_ready;
	assign do_push  = accept && (cmd == CMD_PUSH) && !pending_q;
	assign do_drain = accept && (cmd == CMD_DRAIN) && pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			rep_idx_q <= '0;
			pending_q <= 1'b0;
		end else begin
			if (do_push) begin
				if (col_end) begin
					col_q     <= '0;
					rep_idx_q <= '0;
					pending_q <= 1'b1;
				end else begin
					col_q <= col_next[IDX_W-1:0];
				end
			end
			if (do_drain) begin
				if (rep_end) begin
					rep_idx_q <= '0;
					pending_q <= 1'b0;
				end else begin
					rep_idx_q <= rep_next[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			line_mem[col_q] <= {red, green, blue};
		end
	end

	always_ff @(posedge clk) begin
		if (do_drain) begin
			rd_q <= line_mem[rep_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (do_push) begin
				status_s1  <= ST_FIRST;
				px_s1      <= {red, green, blue};
				row_end_s1 <= col_end;
				pad_s1     <= col_end ? row_pad : PAD_NONE;
			end else if (do_drain) begin
				status_s1  <= ST_SECOND;
				px_s1      <= '0;
				row_end_s1 <= rep_end;
				pad_s1     <= rep_end ? row_pad : PAD_NONE;
			end else begin
				status_s1  <= (cmd == CMD_PUSH) ? ST_REJECT : ST_EMPTY;
				px_s1      <= '0;
				row_end_s1 <= 1'b0;
				pad_s1     <= PAD_NONE;
			end
		end
	end

	assign q_push          = valid_s1;
	assign q_entry.status  = status_s1;
	assign q_entry.pixel   = (status_s1 == ST_SECOND) ? rd_q : px_s1;
	assign q_entry.pad     = pad_s1;
	assign q_entry.row_end = row_end_s1;

endmodule

@@ hw/rtl/upsc_queue.sv @@
// Short queue of classified requests between the front and back parts.
module upsc_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  upsc_pkg::upsc_entry_t       push_entry,
	input  logic                        pop,
	output upsc_pkg::upsc_entry_t       head,
	output logic                        not_empty,
	output logic [upsc_pkg::QCNT_W-1:0] level
);
	import upsc_pkg::*;

	upsc_entry_t       slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign level     = count_q;

endmodule

@@ hw/rtl/upsc_back.sv @@
// Back part: turns queued requests into result pairs held in the output register.
module upsc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  upsc_pkg::upsc_entry_t       head,
	input  logic                        not_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [upsc_pkg::PAIR_W-1:0] pair_bytes,
	output logic [1:0]                  pad_after,
	output logic                        row_end
);
	import upsc_pkg::*;

	logic              valid_q;
	status_t           status_q;
	logic [PAIR_W-1:0] pair_q;
	logic [1:0]        pad_q;
	logic              row_end_q;

	assign pop = not_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q  <= head.status;
			pair_q    <= make_pair(head.pixel);
			pad_q     <= head.pad;
			row_end_q <= head.row_end;
		end
	end

	assign out_valid  = valid_q;
	assign status     = status_q;
	assign pair_bytes = pair_q;
	assign pad_after  = pad_q;
	assign row_end    = row_end_q;

endmodule

@@ hw/rtl/pixel_doubling_upscaler.sv @@
// Top level of the pixel doubling upscaler: front part, request queue and back part.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (source_width, 12 bits)
// in        in         in_valid / in_ready    cmd, blue, green, red
// out       out        out_valid / out_ready  status, pair_bytes, pad_after, row_end
//
// One request is taken per cycle while in_ready is high. The edge that takes a request
// loads the front stage (with the line buffer read); from there the result moves into
// the queue and then into the output register, which presents it.
// The rate is set by the single port of the line buffer, used once per request.
// Reset clears the row counters, the pending replay flag, the queue and the valid
// flag of the output register; the line buffer itself is not cleared and needs no sweep.
// When out_ready is held low the four-entry queue fills and in_ready falls; the
// configuration port never stalls.
module pixel_doubling_upscaler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [47:0] pair_bytes,
	output logic [1:0]  pad_after,
	output logic        row_end
);
	import upsc_pkg::*;

	logic              q_push;
	logic              q_pop;
	logic              q_not_empty;
	logic [QCNT_W-1:0] q_level;
	upsc_entry_t       q_in;
	upsc_entry_t       q_head;

	// The width register is a plain register, so a write is always taken at once.
	assign cfg_ready = 1'b1;

	// The front part holds the row state and the line buffer.  A push writes the
	// pixel at the current column and returns it as a first-row pair; the last
	// pixel of a row arms the replay.  Drains read the buffer back in order as the
	// second-row pairs.  Rejected pushes and empty drains still give one result.
	upsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.q_level   (q_level),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	// The queue lets the front keep taking requests while a finished result waits.
	upsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.not_empty  (q_not_empty),
		.level      (q_level)
	);

	// The back part builds the six-byte pair and holds it until it is taken.
	upsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.not_empty  (q_not_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.pair_bytes (pair_bytes),
		.pad_after  (pad_after),
		.row_end    (row_end)
	);

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the pixel doubling upscaler: predictor, scoreboard and stimulus.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import upsc_pkg::*;

	// The run is stopped as failed if it has not finished by this many cycles.
	// The slowest correct run is roughly 2000 requests, each of which may wait out
	// an input gap and an output stall, so this leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned QUIET_TAIL   = 200;
	localparam int unsigned SHOW_ERRORS  = 10;

	// One expected result, field for field as the block presents it.
	typedef struct packed {
		status_t            status;
		logic [PAIR_W-1:0]  pair;
		logic [1:0]         pad;
		logic               row_end;
	} pair_result_t;

	// Tracks the row and replay state of the upscaler, works out the result of every
	// accepted request and holds those results until the block delivers them.
	class doubling_scoreboard;
		logic [PIX_W-1:0] line_px [MAX_WIDTH];
		bit               written [MAX_WIDTH];
		logic [WID_W-1:0] width_reg;
		int unsigned      col;
		int unsigned      replay_idx;
		bit               replay_pending;
		pair_result_t     pending_pairs[$];
		int unsigned      errors;
		int unsigned      pushes, rejects, drains, empties, row_ends;
		int unsigned      width_writes, widest;

		function new();
			width_reg = 12'd1;
		endfunction

		// A programmed width of zero behaves as one; anything past the line store
		// behaves as the full store.
		function int unsigned effective_width(logic [WID_W-1:0] v);
			if (v == '0)
				return 1;
			if (v > MAX_W)
				return MAX_WIDTH;
			return v;
		endfunction

		function void set_width(logic [WID_W-1:0] v);
			width_reg = v;
			width_writes++;
			if (effective_width(v) > widest)
				widest = effective_width(v);
		endfunction

		// A new width is only safe if the rest of a pending replay reads entries
		// that have been written at some point.
		function bit width_safe(logic [WID_W-1:0] v);
			int unsigned w;
			w = effective_width(v);
			if (!replay_pending)
				return 1'b1;
			for (int unsigned i = replay_idx; i < w; i++)
				if (!written[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function int unsigned pending();
			return pending_pairs.size();
		endfunction

		function void note_request(logic c, logic [7:0] b, logic [7:0] g, logic [7:0] r);
			pair_result_t     e;
			int unsigned      w;
			logic [PIX_W-1:0] px;
			w = effective_width(width_reg);
			e.status  = ST_EMPTY;
			e.pair    = '0;
			e.pad     = PAD_NONE;
			e.row_end = 1'b0;
			if (c == CMD_PUSH) begin
				if (replay_pending) begin
					e.status = ST_REJECT;
					rejects++;
				end else begin
					px = {r, g, b};
					line_px[col] = px;
					written[col] = 1'b1;
					e.status = ST_FIRST;
					e.pair = {px, px};
					pushes++;
					col++;
					// The row closes at the first pixel that reaches or passes the width,
					// which also covers a width lowered part-way through a row.
					if (col >= w) begin
						e.row_end = 1'b1;
						e.pad = (w % 2) ? PAD_ODD : PAD_NONE;
						col = 0;
						replay_pending = 1'b1;
						replay_idx = 0;
						row_ends++;
					end
				end
			end else begin
				if (!replay_pending) begin
					empties++;
				end else begin
					px = line_px[replay_idx];
					e.status = ST_SECOND;
					e.pair = {px, px};
					drains++;
					replay_idx++;
					if (replay_idx >= w) begin
						e.row_end = 1'b1;
						e.pad = (w % 2) ? PAD_ODD : PAD_NONE;
						replay_idx = 0;
						replay_pending = 1'b0;
						row_ends++;
					end
				end
			end
			pending_pairs.push_back(e);
		endfunction

		function void check_result(status_t st, logic [PAIR_W-1:0] pb, logic [1:0] pad,
			logic re);
			pair_result_t e;
			if (pending_pairs.size() == 0) begin
				errors++;
				if (errors <= SHOW_ERRORS)
					$display("%0t: result with nothing expected:", $realtime,
						" status %0d pair %h pad %0d end %0b", st, pb, pad, re);
				return;
			end
			e = pending_pairs.pop_front();
			if (e.status !== st || e.pair !== pb || e.pad !== pad || e.row_end !== re) begin
				errors++;
				if (errors <= SHOW_ERRORS) begin
					$display("%0t: mismatch, expected status %0d pair %h pad %0d end %0b",
						$realtime, e.status, e.pair, e.pad, e.row_end);
					$display("%0t:           actual   status %0d pair %h pad %0d end %0b",
						$realtime, st, pb, pad, re);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [WID_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [7:0]        blue;
	logic [7:0]        green;
	logic [7:0]        red;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [PAIR_W-1:0] pair_bytes;
	logic [1:0]        pad_after;
	logic              row_end;

	doubling_scoreboard sb;

	// Idling controls: each phase decides whether the sender and the receiver pause,
	// and the closing stretch of the run has no pauses at all.
	bit          idle_in;
	bit          idle_out;
	bit          quiet;
	// Every request taken by the block so far, directed ones included.
	int unsigned random_items;
	int unsigned cycle_count;

	pixel_doubling_upscaler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.pair_bytes (pair_bytes),
		.pad_after  (pad_after),
		.row_end    (row_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still outstanding",
			cycle_count, sb.pending());
		$display("** pixel_doubling_upscaler: FAILED **");
		$finish;
	end

	// Receiver side. Outputs are read just after the rising edge, so they still hold
	// the values that the edge itself saw; out_ready only moves on falling edges.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status_t'(status), pair_bytes, pad_after, row_end);
	end

	// Back-pressure: random bursts with out_ready low, taken only in phases that
	// ask for them and never in the closing stretch.
	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_out && !quiet && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Presents one request and waits for the block to take it. in_valid is left high,
	// so a request that follows straight on keeps the channel busy without a bubble;
	// anything else that stops sending must lower it through settle().
	task automatic send_request(input logic c, input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r);
		int unsigned gap;
		gap = 0;
		if (idle_in && !quiet && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 12);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		blue     <= b;
		green    <= g;
		red      <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(c, b, g, r);
		random_items++;
	endtask

	// Colour bytes on a drain are ignored by the block, so they carry noise.
	task automatic send_drain();
		send_request(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Lowers in_valid and waits until every outstanding result has come back. Every
	// request yields exactly one result, so an empty queue means the block is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Programs a new source width with the block idle. If the new width would make
	// the replay in progress read line store entries that were never filled, that
	// replay is finished first.
	task automatic change_width(input logic [WID_W-1:0] v);
		if (!sb.width_safe(v))
			while (sb.replay_pending)
				send_drain();
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_width(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly the well-formed flow (push until a row closes, then drain the replay),
	// with about one request in eight picked at random so that refused pushes and
	// empty drains turn up in every state.
	task automatic send_random_item();
		logic c;
		if ($urandom_range(0, 99) < 12)
			c = 1'($urandom_range(0, 1));
		else
			c = sb.replay_pending ? CMD_DRAIN : CMD_PUSH;
		send_request(c, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [WID_W-1:0] v;
		int unsigned      n;
		int unsigned      w;

		sb = new();
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		cmd          = CMD_PUSH;
		blue         = '0;
		green        = '0;
		red          = '0;
		idle_in      = 1'b1;
		idle_out     = 1'b1;
		quiet        = 1'b0;
		random_items = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, starting from the reset width of one pixel.
		// A drain with nothing to replay, then a white pixel that closes a one-pixel
		// row with two pad bytes, a push refused while the replay waits, the replay
		// itself, and one more drain that again finds nothing.
		send_drain();
		send_request(CMD_PUSH, 8'hFF, 8'hFF, 8'hFF);
		send_request(CMD_PUSH, 8'h00, 8'h00, 8'h00);
		send_drain();
		send_drain();

		// A width of zero must behave as one.
		change_width(12'd0);
		send_request(CMD_PUSH, 8'h12, 8'h34, 8'h56);
		send_drain();

		// Even width: the row ends with no padding.
		change_width(12'd2);
		send_request(CMD_PUSH, 8'h00, 8'hFF, 8'h00);
		send_request(CMD_PUSH, 8'hFF, 8'h00, 8'hFF);
		send_drain();
		send_drain();

		// The largest register value clamps to the full store; the row is left open.
		change_width(12'hFFF);
		send_request(CMD_PUSH, 8'hA5, 8'h5A, 8'hC3);
		send_request(CMD_PUSH, 8'h3C, 8'h96, 8'h69);

		// Lowering the width mid-row: the very next push closes the row even though
		// the count has already reached the new width.
		change_width(12'd2);
		send_request(CMD_PUSH, 8'h01, 8'h80, 8'h7F);
		send_request(CMD_PUSH, 8'hFE, 8'h7F, 8'h80);
		send_drain();

		// Raising the width during a replay; the extra entry was filled above, so
		// the replay simply runs one pixel longer and ends odd, with padding.
		change_width(12'd3);
		send_drain();
		send_drain();

		// Random part, in phases that each program a fresh width. Small widths get
		// whole rows through; large ones mostly end up cut short by a later phase,
		// which exercises the mid-row width change again.
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0:       v = 12'd0;
				1:       v = 12'd1;
				2:       v = 12'hFFF;
				3:       v = 12'd2047;
				4:       v = 12'($urandom_range(MAX_WIDTH + 1, 4095));
				5, 6:    v = 12'($urandom_range(13, 100));
				default: v = 12'($urandom_range(1, 12));
			endcase
			change_width(v);

			quiet    = (random_items + QUIET_TAIL >= RANDOM_ITEMS);
			idle_in  = ($urandom_range(0, 2) != 0);
			idle_out = ($urandom_range(0, 2) != 0);

			w = sb.effective_width(v);
			n = $urandom_range(4, (2 * w + 8 > 60) ? 60 : 2 * w + 8);
			repeat (n)
				send_random_item();
		end

		// Drain everything, then keep watching the output in case the block produces
		// a result nobody asked for.
		settle();
		repeat (8) @(posedge clk);
		sb.errors += sb.pending();

		$display("Covered %0d pixels pushed, %0d refused pushes, %0d replayed pairs,",
			sb.pushes, sb.rejects, sb.drains);
		$display("%0d empty drains, %0d rows closed, %0d width settings,",
			sb.empties, sb.row_ends, sb.width_writes);
		$display("widest effective row %0d pixels, %0d mismatches in %0d cycles.",
			sb.widest, sb.errors, cycle_count);
		if (sb.errors == 0)
			$display("** pixel_doubling_upscaler: PASSED **");
		else
			$display("** pixel_doubling_upscaler: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/upsc_pkg.sv
hw/rtl/upsc_front.sv
hw/rtl/upsc_queue.sv
hw/rtl/upsc_back.sv
hw/rtl/pixel_doubling_upscaler.sv
sim/tb_top.sv
